// File: rtl/core/cpi_pkg.sv
// Shared types and constants for the circle packing insert block.
package cpi_pkg;

	// Square root datapath widths: 34-bit squared distance, 17-bit root.
	localparam int VAL_W  = 34;
	localparam int ROOT_W = 17;
	localparam int REM_W  = 20;
	localparam int GAP_W  = 18;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_HIT  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// Reset value of the radius clamp, 300.0 pixels in Q12.4.
	localparam logic [15:0] MAX_RADIUS_RST = 16'd4800;

	// Control sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_DONE
	} state_t;

	// One lane of the square root chain, handed from cell to cell.
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [VAL_W-1:0]  val;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [15:0]       radius;
	} lane_t;

endpackage

// File: rtl/core/cpi_ram.sv
// Generic simple dual port RAM with registered read.
module cpi_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/cpi_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cycle.
module cpi_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  cpi_pkg::lane_t lane_in,
	output cpi_pkg::lane_t lane_out
);

	logic [cpi_pkg::REM_W-1:0] r4;
	logic [cpi_pkg::REM_W-1:0] trial;
	logic                      ge;
	cpi_pkg::lane_t            nxt;

	// Bring down the next two bits and try the next root bit.
	always_comb begin
		r4    = {lane_in.rem[cpi_pkg::REM_W-3:0], lane_in.val[cpi_pkg::VAL_W-1 -: 2]};
		trial = {1'b0, lane_in.root, 2'b01};
		ge    = (r4 >= trial);
		nxt   = lane_in;
		nxt.val  = {lane_in.val[cpi_pkg::VAL_W-3:0], 2'b00};
		nxt.rem  = ge ? (r4 - trial) : r4;
		nxt.root = {lane_in.root[cpi_pkg::ROOT_W-2:0], ge};
	end

	// Hand the lane to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_out <= '0;
		end else begin
			lane_out <= nxt;
		end
	end

endmodule

// File: rtl/core/circle_packing_insert.sv
// Top level of the greedy circle packing insert block.
//
// Usage: raise start with cand_x and cand_y while busy is low; the item is
// taken at that clock edge. The block then reads every stored circle from
// its table, one per cycle, and sends each through a pipeline of one
// subtract and multiply stage, one add stage and a chain of 17 square root
// cells that each settle one root bit. The smallest gap is tracked at the
// end of the chain. One result follows every item: done is high for exactly
// one cycle with status, new_radius, slot and circle_count. The receiver
// cannot stall, so results are never held.
// The scan of the table goes through one read port. The next item may be
// started in the cycle in which done is shown. The max_radius clamp is
// written with cfg_we and cfg_wdata; the user must write it only while
// idle, as the block itself does not enforce this. Reset clears the
// circle count and the control state, and sets the clamp to 4800; the
// table contents need no clearing because only entries below the count
// are ever read.
module circle_packing_insert #(
	parameter int MAX_CIRCLES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] cand_x,
	input  logic [15:0] cand_y,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] new_radius,
	output logic [7:0]  slot,
	output logic [8:0]  circle_count
);

	localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
	localparam int CW = $clog2(MAX_CIRCLES + 1);
	localparam int NCELL = cpi_pkg::ROOT_W;

	cpi_pkg::state_t state_q, state_d;

	logic [15:0]       max_radius_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [15:0]       cx_q, cy_q;
	logic              issue, last_idx, store, ram_we;
	logic [47:0]       rdata;
	logic              v_s1, last_s1;
	logic [31:0]       sqx_s2, sqy_s2;
	logic [15:0]       rad_s2;
	logic              v_s2, last_s2;
	logic [15:0]       dxa, dya;
	cpi_pkg::lane_t    lane [NCELL+1];
	cpi_pkg::lane_t    tail;
	logic signed [cpi_pkg::GAP_W-1:0] gap, best_q;
	logic              have_q;
	logic              hit;
	logic              full;
	logic [16:0]       rad17;
	logic [15:0]       rad_clamp;
	logic              done_q;
	logic [1:0]        status_q;
	logic [15:0]       new_radius_q;
	logic [7:0]        slot_q;
	logic [8:0]        circle_count_q;

	assign last_idx = (idx_q == count_q - CW'(1));
	assign tail     = lane[NCELL];

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpi_pkg::S_IDLE: begin
				if (start) state_d = (count_q == '0) ? cpi_pkg::S_DONE : cpi_pkg::S_SCAN;
			end
			cpi_pkg::S_SCAN: begin
				if (last_idx) state_d = cpi_pkg::S_WAIT;
			end
			cpi_pkg::S_WAIT: begin
				if (tail.valid && tail.last) state_d = cpi_pkg::S_DONE;
			end
			cpi_pkg::S_DONE: begin
				state_d = cpi_pkg::S_IDLE;
			end
			default: state_d = cpi_pkg::S_IDLE;
		endcase
	end

	// Outcome of the finished scan.
	always_comb begin
		hit       = have_q && best_q[cpi_pkg::GAP_W-1];
		rad17     = have_q ? best_q[16:0] : 17'd0;
		rad_clamp = (rad17 > {1'b0, max_radius_q}) ? max_radius_q : rad17[15:0];
		full      = (count_q == CW'(MAX_CIRCLES));
		store     = !hit && !full;
	end

	// Sequencer outputs.
	always_comb begin
		busy   = (state_q != cpi_pkg::S_IDLE);
		issue  = (state_q == cpi_pkg::S_SCAN);
		ram_we = (state_q == cpi_pkg::S_DONE) && store;
	end

	// State, clamp register, counters and held candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cpi_pkg::S_IDLE;
			max_radius_q <= cpi_pkg::MAX_RADIUS_RST;
			count_q      <= '0;
			idx_q        <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) max_radius_q <= cfg_wdata;
			if (state_q == cpi_pkg::S_IDLE && start) begin
				cx_q  <= cand_x;
				cy_q  <= cand_y;
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ram_we) count_q <= count_q + CW'(1);
		end
	end

	// Circle table: x, y and radius side by side.
	cpi_ram #(
		.WIDTH(48),
		.DEPTH(MAX_CIRCLES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata({cx_q, cy_q, rad_clamp}),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Absolute differences feeding the squares.
	always_comb begin
		dxa = (cx_q >= rdata[47:32]) ? (cx_q - rdata[47:32]) : (rdata[47:32] - cx_q);
		dya = (cy_q >= rdata[31:16]) ? (cy_q - rdata[31:16]) : (rdata[31:16] - cy_q);
	end

	// Read, square and sum stages ahead of the root chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			lane[0] <= '0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && last_idx;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			lane[0].valid  <= v_s2;
			lane[0].last   <= last_s2;
			lane[0].val    <= {2'b00, sqx_s2} + {2'b00, sqy_s2};
			lane[0].rem    <= '0;
			lane[0].root   <= '0;
			lane[0].radius <= rad_s2;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= dxa * dxa;
		sqy_s2 <= dya * dya;
		rad_s2 <= rdata[15:0];
	end

	// Chain of square root cells.
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		cpi_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.lane_in (lane[g]),
			.lane_out(lane[g+1])
		);
	end

	assign gap = $signed({1'b0, tail.root}) - $signed({2'b00, tail.radius});

	// Smallest gap, earliest circle on a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			best_q <= '0;
		end else if (state_q == cpi_pkg::S_IDLE && start) begin
			have_q <= 1'b0;
		end else if (tail.valid && (!have_q || gap < best_q)) begin
			have_q <= 1'b1;
			best_q <= gap;
		end
	end

	// Result registers, shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q         <= 1'b0;
			status_q       <= cpi_pkg::STAT_OK;
			new_radius_q   <= '0;
			slot_q         <= '0;
			circle_count_q <= '0;
		end else begin
			done_q <= (state_q == cpi_pkg::S_DONE);
			if (state_q == cpi_pkg::S_DONE) begin
				if (hit) begin
					status_q       <= cpi_pkg::STAT_HIT;
					new_radius_q   <= '0;
					slot_q         <= '0;
					circle_count_q <= 9'(count_q);
				end else if (full) begin
					status_q       <= cpi_pkg::STAT_FULL;
					new_radius_q   <= rad_clamp;
					slot_q         <= '0;
					circle_count_q <= 9'(count_q);
				end else begin
					status_q       <= cpi_pkg::STAT_OK;
					new_radius_q   <= rad_clamp;
					slot_q         <= 8'(count_q);
					circle_count_q <= 9'(count_q + CW'(1));
				end
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign new_radius   = new_radius_q;
	assign slot         = slot_q;
	assign circle_count = circle_count_q;

`ifndef SYNTH
	// A result follows only the final state of an item.
	a_done_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == cpi_pkg::S_DONE))
		else $error("result strobe without a finished item");

	// The root chain carries data only while an item is being worked on.
	a_chain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy)
		else $error("root chain output while idle");

	// The table never holds more circles than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CIRCLES))
		else $error("circle count beyond table size");

	// The read index stays inside the stored circles during a scan.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (idx_q < count_q))
		else $error("scan index past stored circles");
`endif

endmodule

// File: verif/tb_circle_packing_insert.sv
// Self-checking testbench for the circle packing insert block.
`timescale 1ns / 1ps

module tb_circle_packing_insert;

	localparam int TABLE_DEPTH = 256;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
	} point_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] radius;
		logic [7:0]  slot;
		logic [8:0]  count;
	} placement_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] cand_x;
	logic [15:0] cand_y;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        done;
	logic [1:0]  status;
	logic [15:0] new_radius;
	logic [7:0]  slot;
	logic [8:0]  circle_count;

	// Shadow copy of the circle table and the clamp register.
	logic [15:0] shadow_x [TABLE_DEPTH];
	logic [15:0] shadow_y [TABLE_DEPTH];
	logic [15:0] shadow_r [TABLE_DEPTH];
	int          shadow_count;
	logic [15:0] radius_clamp;

	point_t      pending_points[$];
	placement_t  expected_placements[$];
	int          mismatches;
	int          cycles;
	bit          gaps_on;
	bit          hold_sender;

	circle_packing_insert #(.MAX_CIRCLES(TABLE_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cand_x(cand_x), .cand_y(cand_y), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .status(status), .new_radius(new_radius), .slot(slot),
		.circle_count(circle_count)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [16:0] isqrt34(logic [33:0] v);
		logic [33:0] rem;
		logic [33:0] root;
		logic [33:0] bitv;
		rem = v;
		root = '0;
		bitv = 34'h1 << 32;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root[16:0];
	endfunction

	// Predict the placement of one candidate and update the shadow table.
	function automatic placement_t place_circle(point_t p);
		placement_t  res;
		longint      best;
		longint      gap;
		longint      dx;
		longint      dy;
		logic [33:0] sq;
		longint      rad;
		best = 0;
		res = '0;
		for (int i = 0; i < shadow_count; i++) begin
			dx = longint'(p.x) - longint'(shadow_x[i]);
			dy = longint'(p.y) - longint'(shadow_y[i]);
			sq = 34'(dx * dx + dy * dy);
			gap = longint'(isqrt34(sq)) - longint'(shadow_r[i]);
			if (i == 0 || gap < best)
				best = gap;
		end
		if (shadow_count > 0 && best < 0) begin
			res.status = cpi_pkg::STAT_HIT;
		end else begin
			rad = (shadow_count > 0) ? best : 0;
			if (rad > longint'(radius_clamp))
				rad = radius_clamp;
			res.radius = rad[15:0];
			if (shadow_count >= TABLE_DEPTH) begin
				res.status = cpi_pkg::STAT_FULL;
			end else begin
				res.status = cpi_pkg::STAT_OK;
				res.slot = shadow_count[7:0];
				shadow_x[shadow_count] = p.x;
				shadow_y[shadow_count] = p.y;
				shadow_r[shadow_count] = rad[15:0];
				shadow_count++;
			end
		end
		res.count = shadow_count[8:0];
		return res;
	endfunction

	// Driver: offers one item at a time, with random gaps when gaps_on is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cand_x <= '0;
			cand_y <= '0;
		end else if (start && !busy) begin
			start <= 1'b0;
		end else if (!start && !hold_sender && pending_points.size() > 0
				&& (!gaps_on || $urandom_range(99) >= 26)) begin
			point_t p;
			placement_t pe;
			p = pending_points.pop_front();
			pe = place_circle(p);
			expected_placements = {expected_placements, pe};
			cand_x <= p.x;
			cand_y <= p.y;
			start <= 1'b1;
		end
	end

	// Monitor: compares each result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (done) begin
				if (expected_placements.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result status=%0d radius=%0d", status, new_radius);
				end else begin
					placement_t e;
					e = expected_placements.pop_front();
					if (e.status !== status || e.radius !== new_radius || e.slot !== slot
							|| e.count !== circle_count) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch exp st=%0d r=%0d s=%0d n=%0d got st=%0d r=%0d s=%0d n=%0d",
								e.status, e.radius, e.slot, e.count,
								status, new_radius, slot, circle_count);
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("tb_circle_packing_insert: errors");
				$finish;
			end
		end
	end

	task automatic queue_point(point_t p);
		pending_points = {pending_points, p};
	endtask

	task automatic wait_drained();
		while (pending_points.size() > 0 || start || expected_placements.size() > 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 30) @(posedge clk);
	endtask

	task automatic write_clamp(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		radius_clamp = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic point_t rand_point(int spread);
		point_t p;
		p.x = 16'($urandom_range(spread));
		p.y = 16'($urandom_range(spread));
		return p;
	endfunction

	// Stimulus: directed points, then random phases across clamp settings.
	initial begin
		point_t p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycles = 0;
		mismatches = 0;
		shadow_count = 0;
		radius_clamp = cpi_pkg::MAX_RADIUS_RST;
		gaps_on = 1'b1;
		hold_sender = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table, zero gap, extremes of the coordinates, a hit.
		queue_point('{16'h0000, 16'h0000});
		queue_point('{16'h0000, 16'h0000});
		queue_point('{16'hFFFF, 16'hFFFF});
		queue_point('{16'hFFFF, 16'h0000});
		queue_point('{16'h0000, 16'hFFFF});
		queue_point('{16'h8000, 16'h8000});
		queue_point('{16'h8001, 16'h8000});
		queue_point('{16'h5555, 16'hAAAA});
		queue_point('{16'hAAAA, 16'h5555});
		queue_point('{16'h9000, 16'h8000});
		wait_drained();

		// Sender holds with items pending until all results are in.
		write_clamp(16'hFFFF);
		for (int i = 0; i < 10; i++)
			queue_point(rand_point(65535));
		while (pending_points.size() > 5)
			@(posedge clk);
		hold_sender = 1'b1;
		while (start || expected_placements.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
		wait_drained();

		// A zero clamp makes room for many circles so the table fills up.
		write_clamp(16'd0);
		for (int i = 0; i < 300; i++)
			queue_point(rand_point(65535));
		wait_drained();

		// Table is full now: rejections and full results at mixed clamps.
		write_clamp(16'd40);
		gaps_on = 1'b0;
		for (int i = 0; i < 150; i++)
			queue_point(rand_point(65535));
		wait_drained();
		gaps_on = 1'b1;
		write_clamp(cpi_pkg::MAX_RADIUS_RST);
		for (int i = 0; i < 150; i++)
			queue_point(rand_point(65535));
		wait_drained();
		write_clamp(16'd1);
		for (int i = 0; i < 170; i++)
			queue_point(rand_point(65535));
		for (int i = 0; i < 170; i++)
			queue_point(rand_point(4095));
		wait_drained();

		if (mismatches == 0)
			$display("tb_circle_packing_insert: clean");
		else
			$display("tb_circle_packing_insert: errors");
		$finish;
	end

endmodule
